// ===== rtl/integer_field_formatter_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the integer field formatter
// Each macro expects signals named clk and arst_n in the enclosing module.
// ---------------------------------------------------------------------------
`ifndef INTEGER_FIELD_FORMATTER_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define IFMT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only out of reset.
`define IFMT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ifmt_pkg.sv =====
// ---------------------------------------------------------------------------
// ifmt_pkg
// Shared types, constants and helpers of the integer field formatter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ifmt_pkg;

	localparam int WORD_BITS_DEF   = 32;
	localparam int DIGIT_SLOTS_DEF = 32;
	localparam int MAX_FIELD_DEF   = 64;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] RADIX_OCT = 6'd8;
	localparam logic [5:0] RADIX_HEX = 6'd16;

	// Flag bit positions in format_flags.
	localparam int FLAG_ZEROPAD = 0;
	localparam int FLAG_SIGNED  = 1;
	localparam int FLAG_PLUS    = 2;
	localparam int FLAG_SPACE   = 3;
	localparam int FLAG_LEFT    = 4;
	localparam int FLAG_PREFIX  = 5;
	localparam int FLAG_LOWER   = 6;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	// Everything the character sequencer needs to know about one item.
	typedef struct packed {
		logic       bad;
		logic [7:0] sign_ch;    // zero when no sign is printed
		logic [1:0] pre_len;    // 0, 1 ("0") or 2 ("0x")
		logic       lower;
		logic       zpad;
		logic       left;
		logic [6:0] width;
		logic [5:0] min_digits;
	} fmt_job_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_SHIFT,
		D_WRITE
	} div_state_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_SIZE,
		E_LEAD,
		E_SIGN,
		E_PRE0,
		E_PRE1,
		E_ZPAD,
		E_ZERO,
		E_DRD,
		E_DIG,
		E_TRAIL,
		E_BAD
	} emit_state_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
		logic [7:0] base;
		base = lower ? CH_LO_A : CH_UP_A;
		if (d < 6'd10)
			return CH_ZERO + {2'b00, d};
		else if (d < 6'd36)
			return base + {2'b00, d} - 8'd10;
		else
			return CH_ZERO;
	endfunction

endpackage

// ===== rtl/integer_field_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_field_formatter
// Formats an integer into a field of characters, one character per item out.
// ---------------------------------------------------------------------------
// Input channel (s_*): one item carries value, radix, field width, minimum
// digit count and format flags. s_tready is low from the accepted item until
// its last character has entered the output register.
// Output channel (m_*): one character per item, with m_tlast on the final
// character of a formatted field and m_tuser[0] marking a bad radix (a single
// item with a NUL character and m_tlast set).
// Sequence: for each digit, at least one, the bit-serial divider shifts every
// bit of the value through its remainder and then writes the digit; the
// sequencer then emits the characters, reading each digit from the store
// before it is sent, and steps through the empty phases. The single item of
// a bad radix passes through bad_go_q and the E_BAD state into the output
// register.
// Stalls: a stalled receiver holds the output register and the sequencer
// waits; the next input item is taken while the last character still waits.
// Reset: asynchronous, clears all control state; the digit store is not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_field_formatter_defines.svh"

module integer_field_formatter #(
	parameter int WORD_BITS   = ifmt_pkg::WORD_BITS_DEF,
	parameter int DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
	parameter int MAX_FIELD   = ifmt_pkg::MAX_FIELD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// value[31:0], radix[37:32], field_width[44:38], min_digits[50:45],
	// format_flags[57:51], zeros above
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // char_out[7:0]
	output logic        m_tlast,   // last_char
	output logic [0:0]  m_tuser    // bad_radix[0]
);

	localparam int AW = $clog2(DIGIT_SLOTS);
	localparam int CW = $clog2(DIGIT_SLOTS + 1);

	logic [31:0] value;
	logic [5:0]  radix;
	logic [6:0]  field_width;
	logic [5:0]  min_digits;
	logic [6:0]  format_flags;

	logic                 acc;
	logic                 busy_q;
	logic                 bad_go_q;
	logic [WORD_BITS-1:0] num;
	logic [WORD_BITS-1:0] mag;
	logic                 neg;
	logic                 left_f;

	ifmt_pkg::fmt_job_t job_d, job_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [5:0]    wr_data;
	logic          div_done;
	logic [CW-1:0] dcnt;
	logic          emit_done;

	assign value        = s_tdata[31:0];
	assign radix        = s_tdata[37:32];
	assign field_width  = s_tdata[44:38];
	assign min_digits   = s_tdata[50:45];
	assign format_flags = s_tdata[57:51];

	assign s_tready = !busy_q;
	assign acc      = s_tvalid && !busy_q;

	assign num    = WORD_BITS'(value);
	assign neg    = format_flags[ifmt_pkg::FLAG_SIGNED] && num[WORD_BITS-1];
	// The most negative value negates to itself, which reads right as unsigned.
	assign mag    = neg ? (~num + WORD_BITS'(1)) : num;
	assign left_f = format_flags[ifmt_pkg::FLAG_LEFT];

	always_comb begin
		job_d.bad = (radix < ifmt_pkg::RADIX_MIN) || (radix > ifmt_pkg::RADIX_MAX);
		if (neg)
			job_d.sign_ch = ifmt_pkg::CH_MINUS;
		else if (format_flags[ifmt_pkg::FLAG_PLUS])
			job_d.sign_ch = ifmt_pkg::CH_PLUS;
		else if (format_flags[ifmt_pkg::FLAG_SPACE])
			job_d.sign_ch = ifmt_pkg::CH_SPACE;
		else
			job_d.sign_ch = ifmt_pkg::CH_NUL;
		if (!format_flags[ifmt_pkg::FLAG_PREFIX])
			job_d.pre_len = 2'd0;
		else if (radix == ifmt_pkg::RADIX_HEX)
			job_d.pre_len = 2'd2;
		else if (radix == ifmt_pkg::RADIX_OCT)
			job_d.pre_len = 2'd1;
		else
			job_d.pre_len = 2'd0;
		job_d.lower      = format_flags[ifmt_pkg::FLAG_LOWER];
		job_d.zpad       = format_flags[ifmt_pkg::FLAG_ZEROPAD] && !left_f;
		job_d.left       = left_f;
		job_d.width      = field_width;
		job_d.min_digits = min_digits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			bad_go_q <= 1'b0;
		end else begin
			bad_go_q <= acc && job_d.bad;
			if (acc)
				busy_q <= 1'b1;
			else if (emit_done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			job_q <= job_d;
	end

	ifmt_div #(
		.WORD_BITS  (WORD_BITS),
		.DIGIT_SLOTS(DIGIT_SLOTS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (acc && !job_d.bad),
		.mag    (mag),
		.radix  (radix),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.done   (div_done),
		.count  (dcnt)
	);

	ifmt_emit #(
		.DIGIT_SLOTS(DIGIT_SLOTS),
		.MAX_FIELD  (MAX_FIELD)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.start   (div_done || bad_go_q),
		.job     (job_q),
		.dcnt    (dcnt),
		.done    (emit_done),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	`IFMT_ASSERT_NXT(a_accept_blocks, acc, !s_tready && busy_q, "input taken while busy")
	`IFMT_ASSERT_IMP(a_bad_is_last, m_tvalid && m_tuser[0], m_tlast, "bad radix item not last")
	`IFMT_ASSERT_IMP(a_done_in_busy, emit_done, busy_q, "sequencer finished with no item")
	`IFMT_ASSERT_IMP(a_div_in_busy, div_done, busy_q && !job_q.bad, "digits for a bad radix")

endmodule

// ===== rtl/ifmt_div.sv =====
// ---------------------------------------------------------------------------
// ifmt_div
// Bit-serial restoring divider that peels off digits, least significant first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifmt_div #(
	parameter int WORD_BITS   = ifmt_pkg::WORD_BITS_DEF,
	parameter int DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [WORD_BITS-1:0]             mag,
	input  logic [5:0]                       radix,
	output logic                             wr_en,
	output logic [$clog2(DIGIT_SLOTS)-1:0]   wr_addr,
	output logic [5:0]                       wr_data,
	output logic                             done,
	output logic [$clog2(DIGIT_SLOTS+1)-1:0] count
);

	localparam int AW = $clog2(DIGIT_SLOTS);
	localparam int CW = $clog2(DIGIT_SLOTS + 1);
	localparam int BW = $clog2(WORD_BITS);

	ifmt_pkg::div_state_t st_q, st_d;

	logic [WORD_BITS-1:0] quo_q;
	logic [5:0]           rem_q;
	logic [5:0]           radix_q;
	logic [BW-1:0]        bit_q;
	logic [CW-1:0]        cnt_q;
	logic                 done_q;
	logic [6:0]           trial;
	logic                 qbit;
	logic                 final_digit;

	// One quotient bit per cycle: shift the next dividend bit into the remainder.
	assign trial       = {rem_q, quo_q[WORD_BITS-1]};
	assign qbit        = trial >= {1'b0, radix_q};
	assign final_digit = (quo_q == '0) || (cnt_q == CW'(DIGIT_SLOTS - 1));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ifmt_pkg::D_IDLE:  if (start) st_d = ifmt_pkg::D_SHIFT;
			ifmt_pkg::D_SHIFT: if (bit_q == BW'(WORD_BITS - 1)) st_d = ifmt_pkg::D_WRITE;
			ifmt_pkg::D_WRITE: st_d = final_digit ? ifmt_pkg::D_IDLE : ifmt_pkg::D_SHIFT;
			default:           st_d = ifmt_pkg::D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ifmt_pkg::D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == ifmt_pkg::D_WRITE) && final_digit;
			if (st_q == ifmt_pkg::D_IDLE && start)
				cnt_q <= '0;
			else if (st_q == ifmt_pkg::D_WRITE)
				cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ifmt_pkg::D_IDLE: begin
				quo_q   <= mag;
				radix_q <= radix;
				rem_q   <= '0;
				bit_q   <= '0;
			end
			ifmt_pkg::D_SHIFT: begin
				quo_q <= {quo_q[WORD_BITS-2:0], qbit};
				rem_q <= qbit ? 6'(trial - {1'b0, radix_q}) : trial[5:0];
				bit_q <= bit_q + BW'(1);
			end
			ifmt_pkg::D_WRITE: begin
				rem_q <= '0;
				bit_q <= '0;
			end
			default: begin
				rem_q <= '0;
				bit_q <= '0;
			end
		endcase
	end

	assign wr_en   = (st_q == ifmt_pkg::D_WRITE);
	assign wr_addr = cnt_q[AW-1:0];
	assign wr_data = rem_q;
	assign done    = done_q;
	assign count   = cnt_q;

endmodule

// ===== rtl/ifmt_emit.sv =====
// ---------------------------------------------------------------------------
// ifmt_emit
// Digit store and character sequencer that drives the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ifmt_emit #(
	parameter int DIGIT_SLOTS = ifmt_pkg::DIGIT_SLOTS_DEF,
	parameter int MAX_FIELD   = ifmt_pkg::MAX_FIELD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [$clog2(DIGIT_SLOTS)-1:0]   wr_addr,
	input  logic [5:0]                       wr_data,
	input  logic                             start,
	input  ifmt_pkg::fmt_job_t               job,
	input  logic [$clog2(DIGIT_SLOTS+1)-1:0] dcnt,
	output logic                             done,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [7:0]                       m_tdata,
	output logic                             m_tlast,
	output logic [0:0]                       m_tuser
);

	localparam int AW = $clog2(DIGIT_SLOTS);
	localparam int CW = $clog2(DIGIT_SLOTS + 1);

	logic [5:0] mem [DIGIT_SLOTS];
	logic [5:0] rd_q;
	logic [AW-1:0] raddr;

	ifmt_pkg::emit_state_t st_q, st_d;

	logic [6:0]    prec_d;
	logic [6:0]    zeros_q;
	logic [7:0]    fixed_q;
	logic [6:0]    pad_q;
	logic [7:0]    left_q;
	logic [CW-1:0] dig_q;
	logic [7:0]    total;
	logic [6:0]    pad_d;
	logic [1:0]    sign_len;

	logic       em;
	logic       fire;
	logic       slot_free;
	logic       bad;
	logic [7:0] ch;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;
	logic       out_bad_q;

	assign raddr = AW'(dig_q - CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_q <= mem[raddr];
	end

	assign sign_len  = (job.sign_ch != ifmt_pkg::CH_NUL) ? 2'd1 : 2'd0;
	assign prec_d    = (7'(dcnt) > {1'b0, job.min_digits}) ? 7'(dcnt) : {1'b0, job.min_digits};
	// Padding is owed only when the field is wider than sign, prefix and digits.
	assign pad_d     = ({1'b0, job.width} > fixed_q) ? job.width - fixed_q[6:0] : 7'd0;
	assign total     = (pad_d != 7'd0) ? {1'b0, job.width} : fixed_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		st_d = st_q;
		em   = 1'b0;
		bad  = 1'b0;
		ch   = ifmt_pkg::CH_SPACE;
		unique case (st_q)
			ifmt_pkg::E_IDLE: begin
				if (start) st_d = job.bad ? ifmt_pkg::E_BAD : ifmt_pkg::E_SIZE;
			end
			ifmt_pkg::E_SIZE: st_d = ifmt_pkg::E_LEAD;
			ifmt_pkg::E_LEAD: begin
				if (!job.zpad && !job.left && pad_q != 7'd0) em = 1'b1;
				else st_d = ifmt_pkg::E_SIGN;
			end
			ifmt_pkg::E_SIGN: begin
				if (sign_len != 2'd0) begin
					em = 1'b1;
					ch = job.sign_ch;
					if (slot_free) st_d = ifmt_pkg::E_PRE0;
				end else begin
					st_d = ifmt_pkg::E_PRE0;
				end
			end
			ifmt_pkg::E_PRE0: begin
				if (job.pre_len != 2'd0) begin
					em = 1'b1;
					ch = ifmt_pkg::CH_ZERO;
					if (slot_free) st_d = ifmt_pkg::E_PRE1;
				end else begin
					st_d = ifmt_pkg::E_ZPAD;
				end
			end
			ifmt_pkg::E_PRE1: begin
				if (job.pre_len == 2'd2) begin
					em = 1'b1;
					ch = job.lower ? ifmt_pkg::CH_LO_X : ifmt_pkg::CH_UP_X;
					if (slot_free) st_d = ifmt_pkg::E_ZPAD;
				end else begin
					st_d = ifmt_pkg::E_ZPAD;
				end
			end
			ifmt_pkg::E_ZPAD: begin
				if (!job.left && pad_q != 7'd0) begin
					em = 1'b1;
					ch = job.zpad ? ifmt_pkg::CH_ZERO : ifmt_pkg::CH_SPACE;
				end else begin
					st_d = ifmt_pkg::E_ZERO;
				end
			end
			ifmt_pkg::E_ZERO: begin
				if (zeros_q != 7'd0) begin
					em = 1'b1;
					ch = ifmt_pkg::CH_ZERO;
				end else begin
					st_d = ifmt_pkg::E_DRD;
				end
			end
			// The store read is registered, so each digit is addressed in E_DRD before E_DIG.
			ifmt_pkg::E_DRD: st_d = (dig_q == '0) ? ifmt_pkg::E_TRAIL : ifmt_pkg::E_DIG;
			ifmt_pkg::E_DIG: begin
				em = 1'b1;
				ch = ifmt_pkg::digit_char(rd_q, job.lower);
				if (slot_free) st_d = ifmt_pkg::E_DRD;
			end
			ifmt_pkg::E_TRAIL: begin
				if (pad_q != 7'd0) em = 1'b1;
				else st_d = ifmt_pkg::E_IDLE;
			end
			ifmt_pkg::E_BAD: begin
				em  = 1'b1;
				bad = 1'b1;
				ch  = ifmt_pkg::CH_NUL;
			end
			default: st_d = ifmt_pkg::E_IDLE;
		endcase
		fire = em && slot_free;
		// The character count decides the end, which also covers truncation.
		if (fire && left_q == 8'd1)
			st_d = ifmt_pkg::E_IDLE;
	end

	assign done = (st_q != ifmt_pkg::E_IDLE) && (st_d == ifmt_pkg::E_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ifmt_pkg::E_IDLE;
			out_valid_q <= 1'b0;
			pad_q       <= '0;
			left_q      <= '0;
		end else begin
			st_q <= st_d;
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;

			if (st_q == ifmt_pkg::E_IDLE && start) begin
				left_q <= 8'd1;
			end else if (st_q == ifmt_pkg::E_SIZE) begin
				pad_q  <= pad_d;
				left_q <= (total > 8'(MAX_FIELD)) ? 8'(MAX_FIELD) : total;
			end else if (fire) begin
				left_q <= left_q - 8'd1;
				if (st_q == ifmt_pkg::E_LEAD || st_q == ifmt_pkg::E_ZPAD ||
				    st_q == ifmt_pkg::E_TRAIL)
					pad_q <= pad_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ifmt_pkg::E_IDLE && start) begin
			zeros_q <= prec_d - 7'(dcnt);
			fixed_q <= {1'b0, prec_d} + {6'd0, sign_len} + {6'd0, job.pre_len};
			dig_q   <= dcnt;
		end else if (fire) begin
			if (st_q == ifmt_pkg::E_ZERO)
				zeros_q <= zeros_q - 7'd1;
			if (st_q == ifmt_pkg::E_DIG)
				dig_q <= dig_q - CW'(1);
		end
		if (fire) begin
			out_data_q <= ch;
			out_last_q <= (left_q == 8'd1);
			out_bad_q  <= bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

endmodule
